// File: hdl/iosbc_pkg.sv
// ---------------------------------------------------------------------------
// iosbc_pkg
// Shared types and constants of the I/O space byte-cycle decoder.
// ---------------------------------------------------------------------------
package iosbc_pkg;

  // low address bits kept for the mirrored device block
  localparam int unsigned MirrorBits = 17;
  // each device window spans 2**WinBits bytes
  localparam int unsigned WinBits    = 13;

  // access size codes
  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeWord = 2'd1;
  localparam logic [1:0] SizeLong = 2'd2;

  // window numbers, mirrored address bits [16:13]
  localparam logic [3:0] WinVia1   = 4'h0;  // 0x00000
  localparam logic [3:0] WinVia2   = 4'h1;  // 0x02000
  localparam logic [3:0] WinSerial = 4'h2;  // 0x04000
  localparam logic [3:0] WinHsDma  = 4'h3;  // 0x06000
  localparam logic [3:0] WinDiskReg = 4'h8; // 0x10000
  localparam logic [3:0] WinBlDma  = 4'h9;  // 0x12000
  localparam logic [3:0] WinSound  = 4'hA;  // 0x14000
  localparam logic [3:0] WinFloppy = 4'hB;  // 0x16000

  // data register offset used for writes
  localparam logic [WinBits-1:0] DataRegWrite = 13'h201;

  typedef enum logic [2:0] {
    DevVia1     = 3'd0,
    DevVia2     = 3'd1,
    DevSerial   = 3'd2,
    DevDisk     = 3'd3,
    DevSound    = 3'd4,
    DevFloppy   = 3'd5,
    DevUnmapped = 3'd6
  } dev_t;

  // one byte cycle before decode
  typedef struct packed {
    logic                  wr;
    logic                  dma;
    logic [MirrorBits-1:0] addr;
    logic [7:0]            data;
    logic [1:0]            lane;
    logic                  last;
  } cyc_t;

  // one decoded byte cycle
  typedef struct packed {
    dev_t               dev;
    logic [WinBits-1:0] off;
    logic               wr;
    logic [7:0]         data;
    logic [1:0]         lane;
    logic               last;
  } res_t;

  function automatic logic is_dma_win(logic [3:0] win);
    return (win == WinHsDma) || (win == WinBlDma);
  endfunction

endpackage

// File: hdl/io_space_byte_cycle_decoder.sv
// ---------------------------------------------------------------------------
// io_space_byte_cycle_decoder
// Splits one I/O bus access into device byte cycles, msb first, and decodes
// each cycle to a device window and register offset.
// ---------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  access   | start / busy       | action, access_size, bus_address, write_data
//  cycle    | strobe (no stall)  | target_device, register_offset, is_write,
//           |                    | byte_value, byte_lane, last_cycle
//
//  an access is taken at an edge with start high and busy low
//  byte cycles leave one per clock, the first one after the transfer has
//  passed the access register, then the result register
//  a byte access has one lane, a word two, a longword four: the lane counter
//  in the sequencer steps through them, busy drops during the last lane so
//  accesses follow each other with no gap
//  synchronous active-high reset clears the sequencer and the strobe
//  the receiver has no stall input, every strobe is a completed transfer
//
module io_space_byte_cycle_decoder import iosbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        action,
  input  logic [1:0]  access_size,
  input  logic [31:0] bus_address,
  input  logic [31:0] write_data,
  output logic        busy,
  output logic        strobe,
  output logic [2:0]  target_device,
  output logic [12:0] register_offset,
  output logic        is_write,
  output logic [7:0]  byte_value,
  output logic [1:0]  byte_lane,
  output logic        last_cycle
);

  cyc_t cyc;
  logic cyc_valid;
  res_t res_next;
  res_t res;

  // access register and lane counter
  iosbc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .access_size (access_size),
    .bus_address (bus_address),
    .write_data  (write_data),
    .busy        (busy),
    .cyc_valid   (cyc_valid),
    .cyc         (cyc)
  );

  // window decode of the current lane address
  iosbc_decode u_decode (
    .cyc (cyc),
    .res (res_next)
  );

  // result register, strobe is the only control bit
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cyc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cyc_valid) begin
      res <= res_next;
    end
  end

  assign target_device   = res.dev;
  assign register_offset = res.off;
  assign is_write        = res.wr;
  assign byte_value      = res.data;
  assign byte_lane       = res.lane;
  assign last_cycle      = res.last;

endmodule

// File: hdl/iosbc_seq.sv
// ---------------------------------------------------------------------------
// iosbc_seq
// Holds the accepted access and steps through its byte cycles, one a clock.
// ---------------------------------------------------------------------------
module iosbc_seq import iosbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        action,
  input  logic [1:0]  access_size,
  input  logic [31:0] bus_address,
  input  logic [31:0] write_data,
  output logic        busy,
  output logic        cyc_valid,
  output cyc_t        cyc
);

  logic                  active;
  logic [1:0]            idx;
  logic [1:0]            last_idx;
  logic                  wr;
  logic                  dma;
  logic [MirrorBits-1:0] base;
  logic [31:0]           data;

  logic                  accept;
  logic [1:0]            last_idx_next;
  logic [1:0]            byte_sel;
  logic [MirrorBits-1:0] cyc_addr;

  assign busy   = active && (idx != last_idx);
  assign accept = start && !busy;

  always_comb begin
    case (access_size)
      SizeByte: last_idx_next = 2'd0;
      SizeWord: last_idx_next = 2'd1;
      default:  last_idx_next = 2'd3;  // longword, unused code too
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 2'd0;
    end else if (accept) begin
      active <= 1'b1;
      idx    <= 2'd0;
    end else if (active) begin
      if (idx == last_idx) begin
        active <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_idx <= last_idx_next;
      wr       <= action;
      base     <= bus_address[MirrorBits-1:0];
      data     <= write_data;
      dma      <= access_size[1] &&
                  is_dma_win(bus_address[MirrorBits-1:WinBits]);
    end
  end

  // byte of the data word for this lane, msb first
  assign byte_sel = last_idx - idx;
  assign cyc_addr = base + MirrorBits'(idx);

  assign cyc_valid = active;
  always_comb begin
    cyc.wr   = wr;
    cyc.dma  = dma;
    cyc.addr = cyc_addr;
    cyc.data = wr ? data[{byte_sel, 3'b000} +: 8] : 8'd0;
    cyc.lane = idx;
    cyc.last = (idx == last_idx);
  end

endmodule

// File: hdl/iosbc_decode.sv
// ---------------------------------------------------------------------------
// iosbc_decode
// Maps one mirrored byte cycle address to a device and register offset.
// ---------------------------------------------------------------------------
module iosbc_decode import iosbc_pkg::*; (
  input  cyc_t cyc,
  output res_t res
);

  logic [WinBits-1:0] data_off;
  logic [WinBits-1:0] win_off;

  assign data_off = cyc.wr ? DataRegWrite : '0;
  assign win_off  = cyc.addr[WinBits-1:0];

  always_comb begin
    res.wr   = cyc.wr;
    res.data = cyc.data;
    res.lane = cyc.lane;
    res.last = cyc.last;
    if (cyc.dma) begin
      res.dev = DevDisk;
      res.off = data_off;
    end else begin
      case (cyc.addr[MirrorBits-1:WinBits])
        WinVia1:    begin res.dev = DevVia1;     res.off = win_off;  end
        WinVia2:    begin res.dev = DevVia2;     res.off = win_off;  end
        WinSerial:  begin res.dev = DevSerial;   res.off = win_off;  end
        WinHsDma:   begin res.dev = DevDisk;     res.off = data_off; end
        WinDiskReg: begin res.dev = DevDisk;     res.off = win_off;  end
        WinBlDma:   begin res.dev = DevDisk;     res.off = data_off; end
        WinSound:   begin res.dev = DevSound;    res.off = win_off;  end
        WinFloppy:  begin res.dev = DevFloppy;   res.off = win_off;  end
        default:    begin res.dev = DevUnmapped; res.off = '0;       end
      endcase
    end
  end

endmodule
